FILE: src/nlc_pkg.sv
`timescale 1ns / 1ps
package nlc_pkg;
   localparam int SETS       = 256;
   localparam int WAYS       = 8;
   localparam int LINE_BYTES = 64;
   localparam int MSHR_COUNT = 16;

   localparam int ADDR_W  = 48;
   localparam int OFF_W   = $clog2(LINE_BYTES);
   localparam int SET_W   = $clog2(SETS);
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W  = WAY_W;
   localparam int USED_W  = $clog2(WAYS + 1);
   localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
   localparam int LINE_W  = ADDR_W - OFF_W;
   localparam int MSHR_W  = (MSHR_COUNT > 1) ? $clog2(MSHR_COUNT) : 1;
   localparam int CNT_W   = $clog2(MSHR_COUNT + 1);
   localparam int PEND_W  = 4;
   localparam int TXLOG_W = 2;
   localparam int TXIDX_W = 3;
   localparam int LIMIT_W = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_TXLOG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 1'd1;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FILL  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_HIT       = 3'd0,
      ST_MERGED    = 3'd1,
      ST_ALLOC     = 3'd2,
      ST_NO_MSHR   = 3'd3,
      ST_NO_LINE   = 3'd4,
      ST_FILL_PART = 3'd5,
      ST_FILL_DONE = 3'd6,
      ST_FILL_MISS = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic             dirty;
      logic             ready;
      logic [RANK_W-1:0] rank;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pending;
      logic final_item;
      logic slot_free;
   } dp_stat_type;
endpackage

FILE: src/nlc_if.sv
`timescale 1ns / 1ps
interface nlc_req_if;
   import nlc_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [ADDR_W-1:0] address;
   modport source (output valid, action, address, input ready);
   modport sink (input valid, action, address, output ready);
endinterface

interface nlc_rsp_if;
   import nlc_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        mem_request;
   logic [ADDR_W-1:0] mem_address;
   logic        mem_is_write;
   logic        last;
   modport source (output valid, status, mem_request, mem_address, mem_is_write, last,
                   input ready);
   modport sink (input valid, status, mem_request, mem_address, mem_is_write, last,
                 output ready);
endinterface

FILE: src/nlc_ctrl.sv
`timescale 1ns / 1ps
module nlc_ctrl import nlc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!stat.pending || (stat.slot_free && stat.final_item)) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.commit  = (state_ff == S_LOOKUP);
      cmd.emit    = (state_ff == S_EMIT) && stat.pending && stat.slot_free;
   end
endmodule

FILE: src/nlc_datapath.sv
`timescale 1ns / 1ps
module nlc_datapath import nlc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat,
   input  logic [1:0]            req_action,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic                  rsp_mem_request,
   output logic [ADDR_W-1:0]     rsp_mem_address,
   output logic                  rsp_mem_is_write,
   output logic                  rsp_last
);
   localparam logic [TXLOG_W+1:0] OFF_SH = (TXLOG_W + 2)'(OFF_W);

   logic [TXLOG_W-1:0] txlog_ff;
   logic [LIMIT_W-1:0] limit_ff;

   row_type           mem [SETS];
   logic [SETS-1:0]   row_valid_ff;
   row_type           rd_ff;
   logic              rv_ff;
   action_type        act_ff;
   logic [LINE_W-1:0] line_ff;
   logic              m_hit_ff;
   logic [MSHR_W-1:0] m_idx_ff;

   logic [MSHR_COUNT-1:0] mshr_valid_ff;
   logic [LINE_W-1:0]     mshr_line_ff [MSHR_COUNT];
   logic [WAY_W-1:0]      mshr_way_ff  [MSHR_COUNT];
   logic [PEND_W-1:0]     mshr_pend_ff [MSHR_COUNT];

   logic               stat_left_ff;
   status_type         status_ff;
   logic [PEND_W-1:0]  wb_left_ff, fill_left_ff;
   logic [TXIDX_W-1:0] idx_ff;
   logic [ADDR_W-1:0]  wb_base_ff, fill_base_ff;

   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [2:0]        rsp_status_ff;
   logic              rsp_valid_ff, rsp_req_ff, rsp_wr_ff, rsp_last_ff;

   logic [SET_W-1:0]  req_set, set_q;
   logic [LINE_W-1:0] req_line;
   logic [TAG_W-1:0]  tag_q;
   logic              m_hit;
   logic [MSHR_W-1:0] m_idx;

   row_type           row_cur, row_new;
   logic              hit, free_ok, vic_ok, alloc, wb, dec, release_m, touch_en, wr;
   logic [WAY_W-1:0]  hitw, freew, vicw, tw;
   logic [RANK_W-1:0] tr;
   logic [USED_W-1:0] used_w;
   logic [CNT_W-1:0]  used_m;
   logic              free_m_ok;
   logic [MSHR_W-1:0] free_m;
   logic [PEND_W-1:0] newp, ntx;
   status_type        status_c;
   logic [WAY_W-1:0]  mw;
   logic [4:0]        remaining;
   logic [OFF_W-1:0]  tx_off;

   assign req_line = req_address[ADDR_W-1:OFF_W];
   assign req_set  = req_address[OFF_W +: SET_W];
   assign set_q    = line_ff[SET_W-1:0];
   assign tag_q    = line_ff[LINE_W-1:SET_W];
   assign ntx      = PEND_W'(1) << txlog_ff;
   assign wr       = (act_ff == ACT_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         txlog_ff <= '0;
         limit_ff <= LIMIT_W'(16);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TXLOG: txlog_ff <= csr_write_data[TXLOG_W-1:0];
            CSR_LIMIT: limit_ff <= csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      m_hit = 1'b0;
      m_idx = '0;
      for (int m = 0; m < MSHR_COUNT; m++) begin
         if (!m_hit && mshr_valid_ff[m] && mshr_line_ff[m] == req_line) begin
            m_hit = 1'b1;
            m_idx = MSHR_W'(m);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff    <= mem[req_set];
         act_ff   <= action_type'(req_action);
         line_ff  <= req_line;
         m_hit_ff <= m_hit;
         m_idx_ff <= m_idx;
      end
      if (cmd.commit && act_ff != ACT_NONE) mem[set_q] <= row_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rv_ff        <= 1'b0;
      end else begin
         if (cmd.capture) rv_ff <= row_valid_ff[req_set];
         if (cmd.commit && act_ff != ACT_NONE) row_valid_ff[set_q] <= 1'b1;
      end
   end

   always_comb begin
      row_cur = rv_ff ? rd_ff : '0;
      hit = 1'b0; hitw = '0;
      free_ok = 1'b0; freew = '0;
      vic_ok = 1'b0; vicw = '0;
      used_w = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!hit && row_cur[i].valid && row_cur[i].tag == tag_q) begin
            hit = 1'b1;
            hitw = WAY_W'(i);
         end
         if (!row_cur[i].valid) begin
            if (!free_ok) begin
               free_ok = 1'b1;
               freew = WAY_W'(i);
            end
         end else begin
            used_w = used_w + 1'b1;
            if (row_cur[i].ready && (!vic_ok || row_cur[i].rank > row_cur[vicw].rank)) begin
               vic_ok = 1'b1;
               vicw = WAY_W'(i);
            end
         end
      end
      used_m = CNT_W'($countones(mshr_valid_ff));
      free_m_ok = 1'b0; free_m = '0;
      for (int m = 0; m < MSHR_COUNT; m++) begin
         if (!mshr_valid_ff[m] && !free_m_ok) begin
            free_m_ok = 1'b1;
            free_m = MSHR_W'(m);
         end
      end
   end

   always_comb begin
      row_new = row_cur;
      status_c = ST_HIT;
      alloc = 1'b0; wb = 1'b0; dec = 1'b0; release_m = 1'b0;
      touch_en = 1'b0; tw = hitw; tr = row_cur[hitw].rank;
      mw = mshr_way_ff[m_idx_ff];
      newp = mshr_pend_ff[m_idx_ff] - 1'b1;
      priority if (act_ff == ACT_NONE) begin
         status_c = ST_HIT;
      end else if (act_ff == ACT_FILL) begin
         if (!m_hit_ff) begin
            status_c = ST_FILL_MISS;
         end else begin
            dec = 1'b1;
            if (newp == '0) begin
               row_new[mw].ready = 1'b1;
               release_m = 1'b1;
               status_c = ST_FILL_DONE;
            end else begin
               status_c = ST_FILL_PART;
            end
         end
      end else if (hit && row_cur[hitw].ready) begin
         touch_en = 1'b1;
         status_c = ST_HIT;
      end else if (m_hit_ff) begin
         row_new[mw].dirty = row_cur[mw].dirty | wr;
         status_c = ST_MERGED;
      end else if (7'(used_m) >= 7'(limit_ff) || 7'(used_m) >= 7'(MSHR_COUNT) || !free_m_ok)
      begin
         status_c = ST_NO_MSHR;
      end else if (!free_ok && !vic_ok) begin
         status_c = ST_NO_LINE;
      end else begin
         alloc = 1'b1;
         touch_en = 1'b1;
         status_c = ST_ALLOC;
         if (free_ok) begin
            tw = freew;
            tr = RANK_W'(used_w);
         end else begin
            tw = vicw;
            tr = row_cur[vicw].rank;
            wb = row_cur[vicw].dirty;
         end
      end
      if (touch_en) begin
         for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) != tw && row_cur[i].valid && row_cur[i].rank < tr) begin
               row_new[i].rank = row_cur[i].rank + 1'b1;
            end
         end
         row_new[tw].rank = '0;
         if (alloc) begin
            row_new[tw].valid = 1'b1;
            row_new[tw].tag   = tag_q;
            row_new[tw].dirty = wr;
            row_new[tw].ready = 1'b0;
         end else begin
            row_new[tw].dirty = row_cur[tw].dirty | wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mshr_valid_ff <= '0;
      end else if (cmd.commit) begin
         if (alloc) mshr_valid_ff[free_m] <= 1'b1;
         if (release_m) mshr_valid_ff[m_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && alloc) begin
         mshr_line_ff[free_m] <= line_ff;
         mshr_way_ff[free_m]  <= tw;
         mshr_pend_ff[free_m] <= ntx;
      end
      if (cmd.commit && dec) mshr_pend_ff[m_idx_ff] <= newp;
   end

   assign remaining = 5'(stat_left_ff) + 5'(wb_left_ff) + 5'(fill_left_ff);
   assign tx_off = OFF_W'({{(OFF_W-TXIDX_W){1'b0}}, idx_ff} << (OFF_SH - (TXLOG_W + 2)'(txlog_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_left_ff <= 1'b0;
         wb_left_ff   <= '0;
         fill_left_ff <= '0;
         idx_ff       <= '0;
      end else if (cmd.commit) begin
         stat_left_ff <= (act_ff != ACT_NONE);
         wb_left_ff   <= wb ? ntx : '0;
         fill_left_ff <= alloc ? ntx : '0;
         idx_ff       <= '0;
      end else if (cmd.emit) begin
         if (stat_left_ff) begin
            stat_left_ff <= 1'b0;
         end else if (wb_left_ff != '0) begin
            wb_left_ff <= wb_left_ff - 1'b1;
            idx_ff <= (wb_left_ff == PEND_W'(1)) ? '0 : idx_ff + 1'b1;
         end else begin
            fill_left_ff <= fill_left_ff - 1'b1;
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff    <= status_c;
         wb_base_ff   <= {row_cur[tw].tag, set_q, {OFF_W{1'b0}}};
         fill_base_ff <= {line_ff, {OFF_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_last_ff <= (remaining == 5'd1);
         if (stat_left_ff) begin
            rsp_status_ff <= status_ff;
            rsp_req_ff    <= 1'b0;
            rsp_addr_ff   <= '0;
            rsp_wr_ff     <= 1'b0;
         end else begin
            rsp_status_ff <= ST_ALLOC;
            rsp_req_ff    <= 1'b1;
            rsp_wr_ff     <= (wb_left_ff != '0);
            rsp_addr_ff   <= ((wb_left_ff != '0) ? wb_base_ff : fill_base_ff) |
                             ADDR_W'(tx_off);
         end
      end
   end

   assign stat.pending    = (remaining != '0);
   assign stat.final_item = (remaining == 5'd1);
   assign stat.slot_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_mem_request  = rsp_req_ff;
   assign rsp_mem_address  = rsp_addr_ff;
   assign rsp_mem_is_write = rsp_wr_ff;
   assign rsp_last         = rsp_last_ff;

   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.pending) else $error("emit with nothing left");
   a_alloc_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && alloc |=> mshr_valid_ff[$past(free_m)])
      else $error("allocated MSHR not valid");
   a_fill_match: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && dec |-> mshr_valid_ff[m_idx_ff])
      else $error("fill counted on idle MSHR");
   a_no_commit_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.pending) else $error("commit while items remain");
endmodule

FILE: src/nonblocking_lru_cache_with_mshrs_unit.sv
`timescale 1ns / 1ps
// channel  dir  handshake          payload
// req      in   valid/ready        action, address
// rsp      out  valid/ready        status, mem_request, mem_address, mem_is_write, last
// csr      in   write_enable       index, write_data
//
// An item is accepted while its set is read, then its tag/LRU state is
// updated and its set written back, then its results are loaded into the
// output register one at a time (none for an unused action).
// The set memory is read and written synchronously.
// Reset is synchronous; it clears the per-set row valid flags (so every line reads invalid) and all MSHRs.
// A stalled rsp holds the last item; the next req is taken meanwhile.
module nonblocking_lru_cache_with_mshrs_unit import nlc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   nlc_req_if.sink              req_chan,
   nlc_rsp_if.source            rsp_chan,
   input logic                  csr_write_enable,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_write_data
);
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   nlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nlc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_chan.action),
      .req_address      (req_chan.address),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_mem_request  (rsp_chan.mem_request),
      .rsp_mem_address  (rsp_chan.mem_address),
      .rsp_mem_is_write (rsp_chan.mem_is_write),
      .rsp_last         (rsp_chan.last)
   );
endmodule
